@@ design/ddmp_pkg.sv @@
// ----------------------------------------------------------------------------
// ddmp_pkg
// Shared types and constants of the differential-drive motion profiler.
// ----------------------------------------------------------------------------
package ddmp_pkg;

   localparam int FRAC_BITS_DEF   = 16;
   localparam int SPEED_WIDTH_DEF = 19;
   localparam int GAIN_FRAC       = 16;
   localparam int WORK_W          = 48;
   localparam int QUEUE_DEPTH     = 2;
   localparam int REQ_DATA_W      = 184;
   localparam int CSR_ADDR_W      = 3;
   localparam int CSR_DATA_W      = 18;
   localparam int SQRT_STEPS      = 32;

   localparam logic [CSR_ADDR_W-1:0] CSR_RAMP_STEP  = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_ACCEL      = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_DECEL      = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_GAIN       = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_WHEEL_BASE = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_TURN_ACCEL = 3'd5;

   localparam logic [15:0] RAMP_STEP_RST  = 16'd328;
   localparam logic [17:0] ACCEL_RST      = 18'd32768;
   localparam logic [17:0] DECEL_RST      = 18'd32768;
   localparam logic [15:0] GAIN_RST       = 16'd655;
   localparam logic [16:0] WHEEL_BASE_RST = 17'd16777;
   localparam logic [17:0] TURN_ACCEL_RST = 18'd32768;

   typedef enum logic [1:0] {
      MODE_NONE = 2'd0,
      MODE_STOP = 2'd1,
      MODE_MOVE = 2'd2,
      MODE_TURN = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      SQ_IDLE,
      SQ_MUL_LO,
      SQ_MUL_HI,
      SQ_SUM,
      SQ_SQRT,
      SQ_APPLY,
      SQ_OUT
   } seq_type;

   typedef struct packed {
      logic [1:0]         cmd;
      logic [17:0]        target_speed;
      logic [30:0]        distance;
      logic signed [31:0] turn_angle;
      logic signed [31:0] avg_position;
      logic signed [31:0] heading;
   } item_type;

endpackage

@@ design/diff_drive_motion_profiler.sv @@
// ----------------------------------------------------------------------------
// diff_drive_motion_profiler
// Trapezoidal wheel speed profiler for a differential-drive base.
// ----------------------------------------------------------------------------
// One request beat is one control tick: tuser carries the command (none,
// stop, move, turn), tdata the targets, wheel positions and heading. Each
// request beat yields exactly one response beat with both wheel speed
// commands and the done flag, in order.
// Registers are written through the csr port by index, one per cycle. The
// user must write them only while no tick is in flight; the block does not
// enforce this. A tick that needs a speed cap goes from the input queue
// through two partial products for the cap radicand, a sum and the
// bit-serial square root unit to apply and output; the next tick leaves the
// queue only when the sequencer is back in idle. Stop, idle and finishing
// ticks go straight to apply and output.
// A two-entry queue takes request beats while the sequencer works; an
// output register holds the response, so a stalled receiver only holds
// back the sequencer once a new result is ready.
// Reset is synchronous: stop mode, zero speeds, registers at defaults.
// ----------------------------------------------------------------------------
module diff_drive_motion_profiler #(
   parameter int FRAC_BITS   = ddmp_pkg::FRAC_BITS_DEF,
   parameter int SPEED_WIDTH = ddmp_pkg::SPEED_WIDTH_DEF
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       req_tvalid,
   output logic                                       req_tready,
   // target_speed, distance, turn_angle, left_position, right_position, heading
   input  logic [ddmp_pkg::REQ_DATA_W-1:0]            req_tdata,
   // cmd
   input  logic [1:0]                                 req_tuser,
   output logic                                       rsp_tvalid,
   input  logic                                       rsp_tready,
   // motor_left, motor_right, done_res
   output logic [((2*SPEED_WIDTH+8)/8)*8-1:0]         rsp_tdata,
   input  logic                                       csr_we,
   input  logic [ddmp_pkg::CSR_ADDR_W-1:0]            csr_addr,
   input  logic [ddmp_pkg::CSR_DATA_W-1:0]            csr_wdata
);
   import ddmp_pkg::*;

   localparam int RSP_W = ((2 * SPEED_WIDTH + 8) / 8) * 8;
   localparam int PAD_W = RSP_W - 2 * SPEED_WIDTH - 1;

   item_type                      q_item;
   logic                          q_valid, q_pop;
   logic                          res_valid, res_ready, res_done;
   logic signed [SPEED_WIDTH-1:0] res_left, res_right;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]              rsp_data_ff;

   ddmp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_valid    (q_valid),
      .q_pop      (q_pop),
      .q_item     (q_item)
   );

   ddmp_core #(
      .FRAC_BITS   (FRAC_BITS),
      .SPEED_WIDTH (SPEED_WIDTH)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_pop     (q_pop),
      .q_item    (q_item),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res_left  (res_left),
      .res_right (res_right),
      .res_done  (res_done)
   );

   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && res_ready) begin
         rsp_data_ff <= {{PAD_W{1'b0}}, res_done, res_right, res_left};
      end
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

@@ design/ddmp_sqrt.sv @@
// ----------------------------------------------------------------------------
// ddmp_sqrt
// Iterative 64-bit integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module ddmp_sqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] radicand,
   output logic        done,
   output logic [31:0] root
);
   import ddmp_pkg::*;

   logic [63:0] x_ff, x_in;
   logic [33:0] rem_ff, rem_in;
   logic [31:0] root_ff, root_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [33:0] rem_t, trial;
   logic        ge;

   always_comb begin
      rem_t   = {rem_ff[31:0], x_ff[63:62]};
      trial   = {root_ff, 2'b01};
      ge      = rem_t >= trial;
      x_in    = x_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         x_in    = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         x_in    = {x_ff[61:0], 2'b00};
         rem_in  = ge ? rem_t - trial : rem_t;
         root_in = {root_ff[30:0], ge};
         cnt_in  = cnt_ff + 5'd1;
         if (cnt_ff == 5'(SQRT_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

@@ design/ddmp_front.sv @@
// ----------------------------------------------------------------------------
// ddmp_front
// Input side: takes request beats, averages wheel positions, and queues
// the items for the profile sequencer.
// ----------------------------------------------------------------------------
module ddmp_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [ddmp_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic [1:0]                          req_tuser,
   output logic                                q_valid,
   input  logic                                q_pop,
   output ddmp_pkg::item_type                  q_item
);
   import ddmp_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   item_type          slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   item_type          item;
   logic signed [32:0] pos_sum;
   logic              push;

   always_comb begin
      pos_sum = $signed({req_tdata[112], req_tdata[112:81]})
              + $signed({req_tdata[144], req_tdata[144:113]});
      item.cmd          = req_tuser;
      item.target_speed = req_tdata[17:0];
      item.distance     = req_tdata[48:18];
      item.turn_angle   = $signed(req_tdata[80:49]);
      item.avg_position = pos_sum[32:1];
      item.heading      = $signed(req_tdata[176:145]);
   end

   assign req_tready = count_ff != CNT_W'(QUEUE_DEPTH);
   assign push       = req_tvalid && req_tready;
   assign q_valid    = count_ff != '0;
   assign q_item     = slot_ff[rd_ff];

   always_comb begin
      wr_in    = push ? wr_ff + PTR_W'(1) : wr_ff;
      rd_in    = q_pop ? rd_ff + PTR_W'(1) : rd_ff;
      count_in = count_ff + CNT_W'(push) - CNT_W'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= item;
      end
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

`ifndef SYNTHESIS
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> count_ff != '0)
      else $error("pop from empty queue");
`endif

endmodule

@@ design/ddmp_core.sv @@
// ----------------------------------------------------------------------------
// ddmp_core
// Profile sequencer: updates the mission state, builds the speed cap
// radicand over two partial products, runs the square root and applies
// ramp, cap, heading correction in move mode and saturation, or zero speeds.
// ----------------------------------------------------------------------------
module ddmp_core #(
   parameter int FRAC_BITS   = ddmp_pkg::FRAC_BITS_DEF,
   parameter int SPEED_WIDTH = ddmp_pkg::SPEED_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                q_valid,
   output logic                                q_pop,
   input  ddmp_pkg::item_type                  q_item,
   input  logic                                csr_we,
   input  logic [ddmp_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [ddmp_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output logic                                res_valid,
   input  logic                                res_ready,
   output logic signed [SPEED_WIDTH-1:0]       res_left,
   output logic signed [SPEED_WIDTH-1:0]       res_right,
   output logic                                res_done
);
   import ddmp_pkg::*;

   localparam int CORR_W = 50 - GAIN_FRAC;
   localparam logic signed [WORK_W-1:0] SPD_MAX =
      {{(WORK_W - SPEED_WIDTH + 1){1'b0}}, {(SPEED_WIDTH - 1){1'b1}}};
   localparam logic signed [WORK_W-1:0] SPD_MIN = ~SPD_MAX;

   // configuration
   logic [15:0] ramp_ff, gain_ff;
   logic [17:0] accel_ff, decel_ff, taccel_ff;
   logic [16:0] wb_ff;

   // mission state
   mode_type                 mode_ff;
   logic signed [31:0]       spos_ff, shead_ff, rhead_ff;
   logic signed [SPEED_WIDTH-1:0] lspd_ff, rspd_ff;
   logic [17:0]              hspd_ff;
   logic [30:0]              hdist_ff;
   logic signed [31:0]       hang_ff;
   logic                     fin_ff;

   // work registers
   seq_type                  state_ff, state_in;
   logic [34:0]              opa_ff, opb_ff;
   logic signed [32:0]       hdiff_ff;
   logic signed [CORR_W-1:0] corr_ff;
   logic [52:0]              plo_ff;
   logic [51:0]              phi_ff;
   logic                     zero_ff, sqrt_ff, tpos_ff;

   // load stage
   mode_type                 cmd_mode, mode_n;
   logic                     has_cmd;
   logic signed [31:0]       spos_n, shead_n, rhead_n, hang_n;
   logic [17:0]              hspd_n;
   logic [30:0]              hdist_n;
   logic signed [33:0]       travelled, turned;
   logic signed [34:0]       rem_move, rem_ang;
   logic [34:0]              mag;
   logic                     move_fin, turn_fin, ang_pos;
   logic [17:0]              acc_sel;
   logic [34:0]              acc_wb;

   // sum and apply
   logic [69:0]              full, shifted;
   logic [63:0]              radicand;
   logic                     sqrt_start, sqrt_done;
   logic [31:0]              root;
   logic signed [49:0]       gprod;
   logic signed [WORK_W-1:0] cap, sl0, sr0, sl1, sr1, corr_w, tgt, step;
   logic signed [SPEED_WIDTH-1:0] lspd_n, rspd_n;

   function automatic logic signed [WORK_W-1:0] ramp_up(
      input logic signed [WORK_W-1:0] s, input logic signed [WORK_W-1:0] t,
      input logic signed [WORK_W-1:0] st);
      return (t - s > st) ? s + st : t;
   endfunction

   function automatic logic signed [WORK_W-1:0] ramp_down(
      input logic signed [WORK_W-1:0] s, input logic signed [WORK_W-1:0] t,
      input logic signed [WORK_W-1:0] st);
      return (t + s > st) ? s - st : -t;
   endfunction

   function automatic logic signed [SPEED_WIDTH-1:0] sat_spd(
      input logic signed [WORK_W-1:0] v);
      logic signed [WORK_W-1:0] c;
      c = (v > SPD_MAX) ? SPD_MAX : ((v < SPD_MIN) ? SPD_MIN : v);
      return c[SPEED_WIDTH-1:0];
   endfunction

   ddmp_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (radicand),
      .done     (sqrt_done),
      .root     (root)
   );

   // item load
   always_comb begin
      cmd_mode = mode_type'(q_item.cmd);
      has_cmd  = cmd_mode != MODE_NONE;
      mode_n   = has_cmd ? cmd_mode : mode_ff;
      spos_n   = (has_cmd && (cmd_mode == MODE_MOVE || cmd_mode == MODE_TURN))
               ? q_item.avg_position : spos_ff;
      shead_n  = (has_cmd && cmd_mode == MODE_TURN) ? q_item.heading : shead_ff;
      rhead_n  = (has_cmd && cmd_mode == MODE_MOVE) ? q_item.heading : rhead_ff;
      hspd_n   = has_cmd ? q_item.target_speed : hspd_ff;
      hdist_n  = has_cmd ? q_item.distance : hdist_ff;
      hang_n   = has_cmd ? q_item.turn_angle : hang_ff;

      travelled = 34'(q_item.avg_position) - 34'(spos_n);
      move_fin  = travelled > $signed({3'b000, hdist_n});
      rem_move  = $signed({4'b0000, hdist_n}) - 35'(travelled);

      turned    = 34'(q_item.heading) - 34'(shead_n);
      ang_pos   = !hang_n[31] && (hang_n != '0);
      turn_fin  = ang_pos ? !(turned < 34'(hang_n)) : !(turned > 34'(hang_n));
      rem_ang   = 35'(hang_n) - 35'(turned);
      mag       = rem_ang[34] ? 35'(-rem_ang) : 35'(rem_ang);
      acc_sel   = ang_pos ? taccel_ff : decel_ff;
      acc_wb    = 35'(acc_sel) * 35'(wb_ff);
   end

   // sequencer
   always_comb begin
      state_in   = state_ff;
      q_pop      = 1'b0;
      sqrt_start = 1'b0;
      res_valid  = 1'b0;
      unique case (state_ff)
         SQ_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               if ((mode_n == MODE_MOVE && !move_fin) ||
                   (mode_n == MODE_TURN && !turn_fin)) begin
                  state_in = SQ_MUL_LO;
               end else begin
                  state_in = SQ_APPLY;
               end
            end
         end
         SQ_MUL_LO: state_in = SQ_MUL_HI;
         SQ_MUL_HI: state_in = SQ_SUM;
         SQ_SUM: begin
            sqrt_start = 1'b1;
            state_in   = SQ_SQRT;
         end
         SQ_SQRT: begin
            if (sqrt_done) begin
               state_in = SQ_APPLY;
            end
         end
         SQ_APPLY: state_in = SQ_OUT;
         SQ_OUT: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = SQ_IDLE;
            end
         end
         default: state_in = SQ_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SQ_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // radicand and correction
   always_comb begin
      gprod    = $signed({1'b0, gain_ff}) * hdiff_ff;
      full     = {17'b0, plo_ff} + {phi_ff, 18'b0};
      shifted  = (mode_ff == MODE_TURN) ? (full >> FRAC_BITS) : full;
      radicand = (shifted[69:64] != '0) ? '1 : shifted[63:0];
   end

   // speed update
   always_comb begin
      cap    = $signed({{(WORK_W - 32){1'b0}}, root});
      sl0    = WORK_W'(lspd_ff);
      sr0    = WORK_W'(rspd_ff);
      tgt    = $signed({{(WORK_W - 18){1'b0}}, hspd_ff});
      step   = $signed({{(WORK_W - 16){1'b0}}, ramp_ff});
      corr_w = WORK_W'(corr_ff);
      sl1    = sl0;
      sr1    = sr0;
      if (mode_ff == MODE_MOVE) begin
         sl1 = ramp_up(sl0, tgt, step);
         sr1 = ramp_up(sr0, tgt, step);
         if (sl1 > cap) sl1 = cap;
         if (sr1 > cap) sr1 = cap;
         sl1 = sl1 - corr_w;
         sr1 = sr1 + corr_w;
      end else if (tpos_ff) begin
         sl1 = ramp_down(sl0, tgt, step);
         sr1 = ramp_up(sr0, tgt, step);
         if (-sl1 > cap) sl1 = -cap;
         if (sr1 > cap) sr1 = cap;
      end else begin
         sl1 = ramp_up(sl0, tgt, step);
         sr1 = ramp_down(sr0, tgt, step);
         if (sl1 > cap) sl1 = cap;
         if (-sr1 > cap) sr1 = -cap;
      end
      if (zero_ff) begin
         lspd_n = '0;
         rspd_n = '0;
      end else if (sqrt_ff) begin
         lspd_n = sat_spd(sl1);
         rspd_n = sat_spd(sr1);
      end else begin
         lspd_n = lspd_ff;
         rspd_n = rspd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         opa_ff   <= (mode_n == MODE_MOVE) ? {16'b0, accel_ff, 1'b0} : acc_wb;
         opb_ff   <= (mode_n == MODE_MOVE) ? 35'(rem_move) : mag;
         hdiff_ff <= 33'(rhead_n) - 33'(q_item.heading);
         tpos_ff  <= ang_pos;
      end
      if (state_ff == SQ_MUL_LO) begin
         plo_ff  <= 53'(opa_ff) * 53'(opb_ff[17:0]);
         corr_ff <= gprod[49:GAIN_FRAC];
      end
      if (state_ff == SQ_MUL_HI) begin
         phi_ff <= 52'(opa_ff) * 52'(opb_ff[34:18]);
      end
      if (reset) begin
         ramp_ff   <= RAMP_STEP_RST;
         accel_ff  <= ACCEL_RST;
         decel_ff  <= DECEL_RST;
         gain_ff   <= GAIN_RST;
         wb_ff     <= WHEEL_BASE_RST;
         taccel_ff <= TURN_ACCEL_RST;
         mode_ff   <= MODE_STOP;
         spos_ff   <= '0;
         shead_ff  <= '0;
         rhead_ff  <= '0;
         lspd_ff   <= '0;
         rspd_ff   <= '0;
         hspd_ff   <= '0;
         hdist_ff  <= '0;
         hang_ff   <= '0;
         fin_ff    <= 1'b0;
         zero_ff   <= 1'b0;
         sqrt_ff   <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_addr)
               CSR_RAMP_STEP:  ramp_ff   <= csr_wdata[15:0];
               CSR_ACCEL:      accel_ff  <= csr_wdata;
               CSR_DECEL:      decel_ff  <= csr_wdata;
               CSR_GAIN:       gain_ff   <= csr_wdata[15:0];
               CSR_WHEEL_BASE: wb_ff     <= csr_wdata[16:0];
               CSR_TURN_ACCEL: taccel_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (q_pop) begin
            mode_ff  <= mode_n;
            spos_ff  <= spos_n;
            shead_ff <= shead_n;
            rhead_ff <= rhead_n;
            hspd_ff  <= hspd_n;
            hdist_ff <= hdist_n;
            hang_ff  <= hang_n;
            fin_ff   <= (has_cmd ? 1'b0 : fin_ff)
                      | (mode_n == MODE_MOVE && move_fin)
                      | (mode_n == MODE_TURN && turn_fin);
            zero_ff  <= (mode_n == MODE_STOP)
                      | (mode_n == MODE_MOVE && move_fin)
                      | (mode_n == MODE_TURN && turn_fin);
            sqrt_ff  <= (mode_n == MODE_MOVE && !move_fin)
                      | (mode_n == MODE_TURN && !turn_fin);
         end
         if (state_ff == SQ_APPLY) begin
            lspd_ff <= lspd_n;
            rspd_ff <= rspd_n;
         end
      end
   end

   assign res_left  = lspd_ff;
   assign res_right = rspd_ff;
   assign res_done  = fin_ff;

`ifndef SYNTHESIS
   a_out_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == SQ_OUT && !res_ready) |=> state_ff == SQ_OUT)
      else $error("result dropped while stalled");
   a_stop_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == SQ_OUT && mode_ff == MODE_STOP) |-> (lspd_ff == '0 && rspd_ff == '0))
      else $error("stop mode with nonzero speed");
   a_sqrt_path: assert property (@(posedge clock) disable iff (reset)
      sqrt_done |-> state_ff == SQ_SQRT)
      else $error("square root finished outside its wait state");
`endif

endmodule
